FILE: rtl/hdrl_pkg.sv
`default_nettype none

package hdrl_pkg;

  localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
  localparam logic [31:0] COUNT_MAX  = 32'hffffffff;
  localparam logic [15:0] RATE_RESET = 16'd10;

  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] stamp;
    logic [31:0] count;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_HASH,
    ST_INDEX,
    ST_READ,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/hdrl_if.sv
`default_nettype none

interface hdrl_key_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_byte;
  logic        last_byte;
  logic [31:0] now_seconds;

  modport source (output valid, output key_byte, output last_byte, output now_seconds,
                  input ready);
  modport sink (input valid, input key_byte, input last_byte, input now_seconds,
                output ready);
endinterface

interface hdrl_result_if;
  logic        valid;
  logic        ready;
  logic        emit;
  logic [31:0] repeat_count;

  modport source (output valid, output emit, output repeat_count, input ready);
  modport sink (input valid, input emit, input repeat_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/hdrl_fnv.sv
`default_nettype none

module hdrl_fnv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fold,
  input  wire logic [7:0]  key_byte,
  input  wire logic        last_byte,
  output logic      [63:0] next_hash
);

  logic [63:0] running_hash;
  logic [63:0] x;

  // prime = 2^40 + 0x1b3, so the multiply is seven shifted terms
  always_comb begin
    x = running_hash ^ {56'd0, key_byte};
    next_hash = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= hdrl_pkg::FNV_BASIS;
    end else if (fold) begin
      running_hash <= last_byte ? hdrl_pkg::FNV_BASIS : next_hash;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hdrl_index.sv
`default_nettype none

module hdrl_index #(
  parameter int SLOT_COUNT = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [63:0]                   hash,
  output logic      [$clog2(SLOT_COUNT)-1:0] idx,
  output logic                               done
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (start) begin
          idx <= hash[IDX_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end
    end else begin : g_mod
      localparam int STEPS = 8;
      localparam int CNT_W = $clog2(STEPS);

      logic [63:0]      sh;
      logic [CNT_W-1:0] cnt;
      logic             busy;

      // (rem * 256 + b) mod SLOT_COUNT, one restoring step per bit
      function automatic logic [IDX_W-1:0] mod_byte(input logic [IDX_W-1:0] rem,
                                                    input logic [7:0] b);
        logic [IDX_W:0] r;
        r = {1'b0, rem};
        for (int i = 7; i >= 0; i--) begin
          r = {r[IDX_W-1:0], b[i]};
          if (r >= (IDX_W+1)'(SLOT_COUNT)) begin
            r = r - (IDX_W+1)'(SLOT_COUNT);
          end
        end
        return r[IDX_W-1:0];
      endfunction

      always_ff @(posedge clk) begin
        if (start) begin
          sh  <= hash;
          idx <= '0;
        end else if (busy) begin
          sh  <= sh << 8;
          idx <= mod_byte(idx, sh[63:56]);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          cnt  <= '0;
          done <= 1'b0;
        end else if (start) begin
          busy <= 1'b1;
          cnt  <= '0;
          done <= 1'b0;
        end else if (busy) begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          done <= 1'b0;
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

FILE: rtl/hdrl_slot_mem.sv
`default_nettype none

module hdrl_slot_mem #(
  parameter int SLOT_COUNT = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output hdrl_pkg::slot_t                    rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  wire hdrl_pkg::slot_t               wr_data
);

  hdrl_pkg::slot_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hashed_duplicate_rate_limiter_top.sv
// Duplicate-message rate limiter.
// keys: one beat per key byte (level, colon, message); last_byte ends a key and
//   now_seconds is sampled on it. Bytes are taken one per cycle in ST_HASH only.
// result: one beat per key. emit=0 means suppressed; repeat_count is the number
//   of suppressed repeats of the same key, reported on the emit that ends them.
// cfg_wr_en/cfg_wr_data: suppression window in seconds (reset 10, 0 = off).
// Order: after the last byte the index step runs (a byte-wise modulo unit when
//   SLOT_COUNT is not a power of two), then the slot memory is read and the
//   decision is registered into the result; keys.ready stays low until the
//   decision, so a new key is not taken before the last one is decided.
// Reset: the slot memory is swept to zero, one slot per cycle, every slot once;
//   keys.ready stays low during the sweep.
// Stall: a finished result waits in the output register; the next key's bytes
//   are still taken, and its decision waits until that result is taken.
`default_nettype none

module hashed_duplicate_rate_limiter_top #(
  parameter int SLOT_COUNT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  hdrl_key_if.sink         keys,
  hdrl_result_if.source    result
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  hdrl_pkg::state_t state, state_next;

  logic [15:0]      rate;
  logic [IDX_W-1:0] clear_addr;
  logic [63:0]      key_hash;
  logic [31:0]      key_time;
  logic             out_valid;
  logic             out_emit;
  logic [31:0]      out_count;

  logic [63:0]      next_hash;
  logic [IDX_W-1:0] slot_idx;
  logic             idx_done;
  logic             accept;
  logic             accept_last;

  logic             rd_en;
  hdrl_pkg::slot_t  rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  hdrl_pkg::slot_t  wr_data;

  logic             load_out;
  logic             emit_next;
  logic [31:0]      count_next;
  logic             match;
  logic [32:0]      diff;
  logic             below;

  assign keys.ready   = (state == hdrl_pkg::ST_HASH);
  assign accept       = keys.valid && keys.ready;
  assign accept_last  = accept && keys.last_byte;

  assign result.valid        = out_valid;
  assign result.emit         = out_emit;
  assign result.repeat_count = out_count;

  hdrl_fnv u_fnv (
    .clk       (clk),
    .rst       (rst),
    .fold      (accept),
    .key_byte  (keys.key_byte),
    .last_byte (keys.last_byte),
    .next_hash (next_hash)
  );

  hdrl_index #(.SLOT_COUNT(SLOT_COUNT)) u_index (
    .clk   (clk),
    .rst   (rst),
    .start (accept_last),
    .hash  (next_hash),
    .idx   (slot_idx),
    .done  (idx_done)
  );

  hdrl_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (slot_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // signed age of the slot against the window
  always_comb begin
    match = (rd_data.hash == key_hash);
    diff  = {1'b0, key_time} - {1'b0, rd_data.stamp};
    below = $signed(diff) < $signed({17'd0, rate});
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_idx;
    wr_data    = '0;
    load_out   = 1'b0;
    emit_next  = 1'b1;
    count_next = '0;
    case (state)
      hdrl_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clear_addr;
        if (clear_addr == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = hdrl_pkg::ST_HASH;
        end
      end
      hdrl_pkg::ST_HASH: begin
        if (accept_last) begin
          state_next = hdrl_pkg::ST_INDEX;
        end
      end
      hdrl_pkg::ST_INDEX: begin
        if (idx_done) begin
          state_next = hdrl_pkg::ST_READ;
        end
      end
      hdrl_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = hdrl_pkg::ST_DECIDE;
      end
      hdrl_pkg::ST_DECIDE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = hdrl_pkg::ST_HASH;
          if (rate == 16'd0) begin
            emit_next = 1'b1;
          end else if (match && below) begin
            emit_next     = 1'b0;
            wr_en         = 1'b1;
            wr_data       = rd_data;
            if (rd_data.count != hdrl_pkg::COUNT_MAX) begin
              wr_data.count = rd_data.count + 32'd1;
            end
          end else begin
            emit_next     = 1'b1;
            count_next    = match ? rd_data.count : 32'd0;
            wr_en         = 1'b1;
            wr_data.hash  = key_hash;
            wr_data.stamp = key_time;
            wr_data.count = 32'd0;
          end
        end
      end
      default: begin
        state_next = hdrl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hdrl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == hdrl_pkg::ST_CLEAR) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= hdrl_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      rate <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_last) begin
      key_hash <= next_hash;
      key_time <= keys.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_emit  <= emit_next;
      out_count <= count_next;
    end
  end

  a_suppressed_zero_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.emit |-> result.repeat_count == 32'd0)
    else $error("suppressed beat carries a nonzero count");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == hdrl_pkg::ST_DECIDE)
    else $error("result beat raised outside the decision step");

  a_no_write_when_off: assert property (@(posedge clk) disable iff (rst)
    state == hdrl_pkg::ST_DECIDE && rate == 16'd0 |-> !wr_en)
    else $error("slot written with suppression off");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == hdrl_pkg::ST_CLEAR || state == hdrl_pkg::ST_DECIDE)
    else $error("slot write outside sweep or decision");

  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    accept_last |=> !keys.ready)
    else $error("new byte taken before the key decision");

endmodule

`default_nettype wire

FILE: dv/hdrl_suppression_monitor.sv
`default_nettype none

module hdrl_suppression_monitor #(
  parameter int SLOT_COUNT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  hdrl_key_if              keys,
  hdrl_result_if           result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  typedef struct packed {
    logic        emit;
    logic [31:0] repeat_count;
  } verdict_t;

  logic [15:0]     window;
  logic [63:0]     key_hash;
  hdrl_pkg::slot_t slots [SLOT_COUNT];
  verdict_t        awaited [$];
  int              fail_count = 0;

  // Fold one accepted key beat; on the last byte decide and queue the verdict.
  task automatic fold_key_byte(input logic [7:0] b, input logic last, input logic [31:0] t);
    logic [63:0] h;
    int          idx;
    longint      age;
    verdict_t    v;
    h = (key_hash ^ {56'd0, b}) * FNV_PRIME;
    if (!last) begin
      key_hash = h;
    end else begin
      key_hash = hdrl_pkg::FNV_BASIS;
      v.emit = 1'b1;
      v.repeat_count = '0;
      if (window != 16'd0) begin
        idx = int'(h % 64'(SLOT_COUNT));
        // signed age: a clock that went back counts as inside the window
        age = longint'({32'd0, t}) - longint'({32'd0, slots[idx].stamp});
        if (slots[idx].hash == h && age < longint'({48'd0, window})) begin
          if (slots[idx].count != hdrl_pkg::COUNT_MAX) begin
            slots[idx].count = slots[idx].count + 32'd1;
          end
          v.emit = 1'b0;
        end else begin
          if (slots[idx].hash == h) begin
            v.repeat_count = slots[idx].count;
          end
          slots[idx].hash = h;
          slots[idx].stamp = t;
          slots[idx].count = '0;
        end
      end
      awaited.push_back(v);
    end
  endtask

  task automatic check_result(input logic emit, input logic [31:0] repeat_count);
    verdict_t v;
    if (awaited.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result beat emit=%0b repeat_count=%0d", $time, emit,
               repeat_count);
    end else begin
      v = awaited.pop_front();
      if (emit !== v.emit) begin
        fail_count++;
        $display("%0t: emit mismatch, expected %0b, got %0b", $time, v.emit, emit);
      end
      if (repeat_count !== v.repeat_count) begin
        fail_count++;
        $display("%0t: repeat_count mismatch, expected %0d, got %0d", $time,
                 v.repeat_count, repeat_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window = hdrl_pkg::RATE_RESET;
      key_hash = hdrl_pkg::FNV_BASIS;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] = '0;
      end
      awaited.delete();
    end else begin
      if (cfg_wr_en) begin
        window = cfg_wr_data;
      end
      if (keys.valid && keys.ready) begin
        fold_key_byte(keys.key_byte, keys.last_byte, keys.now_seconds);
      end
      if (result.valid && result.ready) begin
        check_result(result.emit, result.repeat_count);
      end
    end
    errors <= fail_count;
    pending <= awaited.size();
  end

endmodule

`default_nettype wire

FILE: dv/hashed_duplicate_rate_limiter_top_tb.sv
`default_nettype none

module hashed_duplicate_rate_limiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT  = 512;
  localparam int POOL_SIZE   = 6;
  localparam int MAX_KEY_LEN = 24;
  localparam int STALL_LIMIT = 2500;
  localparam int PHASE_BYTES = 180;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  int          errors;
  int          pending;

  hdrl_key_if    keys ();
  hdrl_result_if result ();

  hashed_duplicate_rate_limiter_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .keys(keys),
    .result(result)
  );

  hdrl_suppression_monitor #(
    .SLOT_COUNT(SLOT_COUNT)
  ) suppression_mon (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .keys(keys),
    .result(result),
    .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  bit          calm_keys;
  bit          calm_results;
  int          idle_cycles = 0;
  logic [31:0] now_clock;
  logic [7:0]  key_text [$];
  logic [7:0]  pool_bytes [POOL_SIZE][MAX_KEY_LEN];
  int          pool_len [POOL_SIZE];

  // stretches with no idling on either side
  initial begin
    calm_keys = 1'b0;
    calm_results = 1'b0;
    forever begin
      repeat ($urandom_range(20, 150)) @(posedge clk);
      calm_keys = ($urandom_range(0, 3) == 0);
      calm_results = ($urandom_range(0, 3) == 0);
    end
  end

  // result side: random stall before each beat
  initial begin
    int stall;
    result.ready <= 1'b0;
    forever begin
      stall = calm_results ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid && result.ready));
    end
  end

  always @(posedge clk) begin
    if ((keys.valid && keys.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("hashed_duplicate_rate_limiter_top_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last, input logic [31:0] t);
    int gap;
    gap = calm_keys ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      keys.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys.valid <= 1'b1;
    keys.key_byte <= b;
    keys.last_byte <= last;
    keys.now_seconds <= t;
    do @(posedge clk); while (!keys.ready);
  endtask

  // now_seconds only matters on the last beat; other beats carry noise
  task automatic send_key(input logic [31:0] stamp);
    int n;
    n = key_text.size();
    for (int i = 0; i < n; i++) begin
      send_beat(key_text[i], i == n - 1, (i == n - 1) ? stamp : $urandom());
    end
  endtask

  task automatic load_text(input string s);
    key_text.delete();
    for (int i = 0; i < s.len(); i++) begin
      key_text.push_back(s[i]);
    end
  endtask

  task automatic load_byte(input logic [7:0] b);
    key_text.delete();
    key_text.push_back(b);
  endtask

  // block idle: every queued verdict has come back, then slack before returning
  task automatic settle();
    keys.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly repeats of a small key pool so slots hit, age out and get evicted.
  task automatic random_phase(input logic [15:0] w, input int budget);
    int sent;
    int pick;
    int len;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_KEY_LEN)
                                                : $urandom_range(1, 6);
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        pool_bytes[k][j] = 8'($urandom_range(0, 255));
      end
    end
    sent = 0;
    while (sent < budget) begin
      key_text.delete();
      if ($urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        for (int j = 0; j < pool_len[pick]; j++) begin
          key_text.push_back(pool_bytes[pick][j]);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          key_text.push_back(8'($urandom_range(0, 255)));
        end
      end
      case ($urandom_range(0, 9))
        0: now_clock = now_clock - $urandom_range(1, 40);
        1: now_clock = $urandom();
        2, 3, 4: now_clock = now_clock + $urandom_range(0, 32'(w) + 32'(w) / 2 + 2);
        default: now_clock = now_clock + $urandom_range(0, 2);
      endcase
      send_key(now_clock);
      sent += key_text.size();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    keys.valid <= 1'b0;
    keys.key_byte <= '0;
    keys.last_byte <= 1'b0;
    keys.now_seconds <= '0;
    now_clock = 32'd1000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset window of 10: suppress, count, expire, clock going back
    load_text("E:x");
    send_key(32'd100);
    send_key(32'd105);
    send_key(32'd109);
    send_key(32'd110);
    send_key(32'd50);
    load_text("W:");
    send_key(32'd0);
    load_byte(8'h00);
    send_key(32'd0);
    // extreme times: wrap from max to zero reads as a negative age
    load_byte(8'hff);
    send_key(32'hffffffff);
    send_key(32'd0);
    send_key(32'hffffffff);
    settle();

    set_window(16'd0);
    random_phase(16'd0, PHASE_BYTES);
    settle();
    set_window(16'hffff);
    random_phase(16'hffff, PHASE_BYTES);
    settle();
    set_window(16'd1);
    random_phase(16'd1, PHASE_BYTES);
    settle();
    set_window(16'($urandom_range(2, 40)));
    random_phase(cfg_wr_data, PHASE_BYTES);
    settle();
    set_window(16'd10);
    random_phase(16'd10, PHASE_BYTES);
    settle();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("hashed_duplicate_rate_limiter_top_tb: done, clean");
    end else begin
      $display("hashed_duplicate_rate_limiter_top_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/hdrl_pkg.sv
rtl/hdrl_if.sv
rtl/hdrl_fnv.sv
rtl/hdrl_index.sv
rtl/hdrl_slot_mem.sv
rtl/hashed_duplicate_rate_limiter_top.sv
dv/hdrl_suppression_monitor.sv
dv/hashed_duplicate_rate_limiter_top_tb.sv
